// ----- rtl/vk3d_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and code functions of the K=3 rate-1/2 byte decoder.
// No dependencies; every other file imports this package.
package vk3d_pkg;

  localparam int unsigned TAP_W    = 3;
  localparam int unsigned METRIC_W = 4;
  localparam int unsigned NSTATES  = 4;
  localparam int unsigned NSTEPS   = 4;
  localparam int unsigned HIST_W   = NSTATES * NSTEPS;

  localparam logic [METRIC_W-1:0] METRIC_INF = 4'd15;

  localparam logic REG_GEN_A = 1'b0;
  localparam logic REG_GEN_B = 1'b1;

  typedef logic [TAP_W-1:0]    taps_t;
  typedef logic [METRIC_W-1:0] metric_t;

  // One byte on its way through the trellis: unread symbols, path metrics,
  // survivor decisions (one bit per state and step, odd predecessor chosen).
  typedef struct packed {
    logic [7:0]                syms;
    metric_t [NSTATES-1:0]     pm;
    logic [HIST_W-1:0]         hist;
  } lane_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

  // Two code bits for input u entering from trellis state p.
  function automatic logic [1:0] code_pair(input logic [1:0] p, input logic u,
                                           input taps_t ga, input taps_t gb);
    logic [2:0] sr;
    sr = {u, p};
    return {^(sr & ga), ^(sr & gb)};
  endfunction

  function automatic metric_t branch_add(input metric_t pm, input logic [1:0] sym,
                                         input logic [1:0] code);
    logic [1:0]          d;
    logic [METRIC_W:0]   s;
    d = sym ^ code;
    s = {1'b0, pm} + {{METRIC_W{1'b0}}, d[1]} + {{METRIC_W{1'b0}}, d[0]};
    return (s > {1'b0, METRIC_INF}) ? METRIC_INF : s[METRIC_W-1:0];
  endfunction

endpackage

// ----- rtl/vk3d_acs_stage.sv -----
`timescale 1ns / 1ps
// One pipelined add-compare-select trellis step for both byte lanes.
// Depends on vk3d_pkg for lane_t, code_pair and branch_add.
module vk3d_acs_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  vk3d_pkg::stage_ctl_t ctl,
  input  vk3d_pkg::taps_t     gen_a,
  input  vk3d_pkg::taps_t     gen_b,
  input  vk3d_pkg::lane_t     lane_lo,
  input  vk3d_pkg::lane_t     lane_hi,
  output logic                valid,
  output vk3d_pkg::lane_t     lane_lo_q,
  output vk3d_pkg::lane_t     lane_hi_q
);
  import vk3d_pkg::*;

  logic  valid_r, valid_nxt;
  lane_t lane_lo_r, lane_hi_r;
  lane_t lo_nxt, hi_nxt;

  function automatic lane_t acs(input lane_t ln, input taps_t ga, input taps_t gb);
    lane_t       r;
    logic [1:0]  sym;
    logic [1:0]  pe;
    logic [1:0]  po;
    metric_t     me;
    metric_t     mo;
    logic [NSTATES-1:0] dec;
    sym = ln.syms[7:6];
    r.syms = {ln.syms[5:0], 2'b00};
    for (int s = 0; s < NSTATES; s++) begin
      pe = {s[0], 1'b0};
      po = {s[0], 1'b1};
      me = branch_add(ln.pm[pe], sym, code_pair(pe, s[1], ga, gb));
      mo = branch_add(ln.pm[po], sym, code_pair(po, s[1], ga, gb));
      dec[s]  = (mo < me);
      r.pm[s] = (mo < me) ? mo : me;
    end
    r.hist = {ln.hist[HIST_W-NSTATES-1:0], dec};
    return r;
  endfunction

  always_comb begin
    lo_nxt    = acs(lane_lo, gen_a, gen_b);
    hi_nxt    = acs(lane_hi, gen_a, gen_b);
    valid_nxt = ctl.advance ? ctl.valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      lane_lo_r <= lo_nxt;
      lane_hi_r <= hi_nxt;
    end
  end

  assign valid     = valid_r;
  assign lane_lo_q = lane_lo_r;
  assign lane_hi_q = lane_hi_r;

endmodule

// ----- rtl/vk3d_traceback.sv -----
`timescale 1ns / 1ps
// Final state selection and four-step traceback for both lanes; output register.
// Depends on vk3d_pkg for lane_t and stage_ctl_t.
module vk3d_traceback (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vk3d_pkg::stage_ctl_t ctl,
  input  vk3d_pkg::lane_t      lane_lo,
  input  vk3d_pkg::lane_t      lane_hi,
  output logic                 valid,
  output logic [7:0]           decoded
);
  import vk3d_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] decoded_r, decoded_nxt;

  function automatic logic [3:0] trace(input lane_t ln);
    logic [1:0] best;
    metric_t    bestm;
    logic [1:0] s;
    logic [3:0] nib;
    best  = 2'd0;
    bestm = ln.pm[0];
    for (int i = 1; i < NSTATES; i++) begin
      if (ln.pm[i] < bestm) begin
        bestm = ln.pm[i];
        best  = i[1:0];
      end
    end
    s = best;
    // hist[3:0] holds the last step, hist[15:12] the first
    for (int k = 0; k < NSTEPS; k++) begin
      nib[k] = s[1];
      s      = {s[0], ln.hist[k*NSTATES + s]};
    end
    return nib;
  endfunction

  always_comb begin
    decoded_nxt = {trace(lane_hi), trace(lane_lo)};
    valid_nxt   = ctl.advance ? ctl.valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      decoded_r <= decoded_nxt;
    end
  end

  assign valid   = valid_r;
  assign decoded = decoded_r;

endmodule

// ----- rtl/viterbi_k3_rate_half_byte_decoder.sv -----
`timescale 1ns / 1ps
// Hard-decision Viterbi decoder, K=3 rate 1/2, two coded bytes in, one decoded byte out.
// Takes one transfer per cycle while in_stall is low; out_valid rises once its input transfer
// has passed four trellis-step stages and one traceback/output stage, the first loaded by the
// transfer itself. Stages advance independently, so bubbles collapse and in_stall
// rises only when all five stages are full and out_stall holds the output.
// Depends on vk3d_pkg, vk3d_acs_stage, vk3d_traceback.
module viterbi_k3_rate_half_byte_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_first_coded_byte,
  input  logic [7:0]          in_second_coded_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_decoded_byte,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  vk3d_pkg::taps_t     cfg_wdata
);
  import vk3d_pkg::*;

  localparam int unsigned NST = NSTEPS + 1;

  taps_t gen_a_r, gen_a_nxt;
  taps_t gen_b_r, gen_b_nxt;

  logic  [NST-1:0] v;
  logic  [NST-1:0] adv;
  lane_t           lo [NSTEPS+1];
  lane_t           hi [NSTEPS+1];
  stage_ctl_t      ctl [NST];

  always_comb begin
    gen_a_nxt = gen_a_r;
    gen_b_nxt = gen_b_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_GEN_A: gen_a_nxt = cfg_wdata;
        REG_GEN_B: gen_b_nxt = cfg_wdata;
        default:   gen_a_nxt = gen_a_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_a_r <= 3'd7;
      gen_b_r <= 3'd5;
    end else begin
      gen_a_r <= gen_a_nxt;
      gen_b_r <= gen_b_nxt;
    end
  end

  // Advance a stage when it is empty or its successor advances.
  always_comb begin
    adv[NST-1] = !v[NST-1] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
    ctl[0] = '{valid: in_valid, advance: adv[0]};
    for (int i = 1; i < NST; i++) begin
      ctl[i] = '{valid: v[i-1], advance: adv[i]};
    end
  end

  assign in_stall = !adv[0];

  assign lo[0] = '{syms: in_first_coded_byte,
                   pm: {METRIC_INF, METRIC_INF, METRIC_INF, {METRIC_W{1'b0}}},
                   hist: '0};
  assign hi[0] = '{syms: in_second_coded_byte,
                   pm: {METRIC_INF, METRIC_INF, METRIC_INF, {METRIC_W{1'b0}}},
                   hist: '0};

  for (genvar g = 0; g < NSTEPS; g++) begin : g_acs
    vk3d_acs_stage u_acs (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl[g]),
      .gen_a     (gen_a_r),
      .gen_b     (gen_b_r),
      .lane_lo   (lo[g]),
      .lane_hi   (hi[g]),
      .valid     (v[g]),
      .lane_lo_q (lo[g+1]),
      .lane_hi_q (hi[g+1])
    );
  end

  vk3d_traceback u_tb (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl[NST-1]),
    .lane_lo (lo[NSTEPS]),
    .lane_hi (hi[NSTEPS]),
    .valid   (v[NST-1]),
    .decoded (out_decoded_byte)
  );

  assign out_valid = v[NST-1];

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v) && out_stall)
    else $error("input stalled with an empty stage");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_cfg_a: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index == REG_GEN_A |=> gen_a_r == $past(cfg_wdata))
    else $error("gen_a write lost");

  a_cfg_b: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index == REG_GEN_B |=> gen_b_r == $past(cfg_wdata))
    else $error("gen_b write lost");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    v[NST-2] && !adv[NST-1] |=> v[NST-2])
    else $error("stage data dropped under stall");

endmodule
